@@ rtl/spq_pkg.sv @@
// spq_pkg: types and codes shared by the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
`default_nettype none

package spq_pkg;

    localparam int unsigned DataW = 16;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One slot of the queue.
    typedef struct packed {
        logic             vld;
        logic [DataW-1:0] pri;
        logic [DataW-1:0] tag;
    } t_entry;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [DataW-1:0] pri;
        logic [DataW-1:0] tag;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// spq_cell: one slot of the sorted queue; holds an entry, shifts toward either neighbor.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_strict,
    input  wire spq_pkg::t_cmd  i_cmd,
    input  wire spq_pkg::t_entry i_prev_ent,
    input  wire logic           i_prev_at,
    input  wire spq_pkg::t_entry i_next_ent,
    output spq_pkg::t_entry     o_ent,
    output logic                o_at
);

    spq_pkg::t_entry r_ent;
    spq_pkg::t_entry n_ent;

    // New entry belongs here or further toward the front.
    always_comb begin
        if (!r_ent.vld) begin
            o_at = 1'b1;
        end else if (i_strict) begin
            o_at = (r_ent.pri < i_cmd.pri);
        end else begin
            o_at = (r_ent.pri <= i_cmd.pri);
        end
    end

    always_comb begin
        n_ent = r_ent;
        if (i_cmd.ins) begin
            if (i_prev_at) begin
                n_ent = i_prev_ent;
            end else if (o_at) begin
                n_ent.vld = 1'b1;
                n_ent.pri = i_cmd.pri;
                n_ent.tag = i_cmd.tag;
            end
        end else if (i_cmd.rem) begin
            n_ent = i_next_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent.pri <= n_ent.pri;
        r_ent.tag <= n_ent.tag;
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
        end else begin
            r_ent.vld <= n_ent.vld;
        end
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue_top.sv @@
// Channel | Valid       | Stall       | Payload
// in      | i_in_valid  | o_in_stall  | i_mode, i_priority_req, i_tag
// out     | o_out_valid | i_out_stall | o_status, o_out_tag, o_out_priority,
//         |             |             | o_fill_count, o_is_empty
// One word per cycle unless stalled: every cell compares against the new priority
// in parallel and takes its own, a neighbor's or the new entry in the same cycle.
// The result word appears in the output register in the cycle after acceptance.
// Input stalls only while a result waits and the output side stalls.
// Synchronous active-low reset empties the queue; no clearing pass.
// sorted_priority_queue_top: chain of spq_cell slots plus count and output register.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_priority_req,
    input  wire logic [15:0] i_tag,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_tag,
    output logic [15:0]      o_out_priority,
    output logic [4:0]       o_fill_count,
    output logic             o_is_empty
);

    localparam int unsigned CntW = $clog2(CAPACITY + 1);

    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    spq_pkg::t_cmd   w_cmd;
    spq_pkg::t_entry w_ent [CAPACITY];
    logic            w_at  [CAPACITY];
    logic [CAPACITY-1:0] w_vld;
    spq_pkg::t_entry w_none;

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [1:0]      r_status;
    logic [1:0]      n_status;
    logic [15:0]     r_tag;
    logic [15:0]     n_tag;
    logic [15:0]     r_pri;
    logic [15:0]     n_pri;
    logic [CntW-1:0] r_res_count;
    logic [CntW+4:0] w_cnt_ext;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CntW'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_cmd.ins = w_accept && (i_mode == spq_pkg::MODE_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (i_mode == spq_pkg::MODE_REMOVE) && !w_empty;
    assign w_cmd.pri = i_priority_req;
    assign w_cmd.tag = i_tag;

    assign w_none = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_strict   ((g == 0) ? 1'b1 : 1'b0),
            .i_cmd      (w_cmd),
            .i_prev_ent ((g == 0) ? w_none : w_ent[(g == 0) ? 0 : g-1]),
            .i_prev_at  ((g == 0) ? 1'b0 : w_at[(g == 0) ? 0 : g-1]),
            .i_next_ent ((g == CAPACITY-1) ? w_none
                                           : w_ent[(g == CAPACITY-1) ? g : g+1]),
            .o_ent      (w_ent[g]),
            .o_at       (w_at[g])
        );
        assign w_vld[g] = w_ent[g].vld;
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        n_tag    = w_ent[0].tag;
        n_pri    = w_ent[0].pri;
        if (i_mode == spq_pkg::MODE_INSERT) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CntW'(1);
                if (w_at[0]) begin
                    n_tag = i_tag;
                    n_pri = i_priority_req;
                end
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
                n_tag    = '0;
                n_pri    = '0;
            end else begin
                n_count = r_count - CntW'(1);
            end
        end
    end

    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_tag    <= n_tag;
            r_pri    <= n_pri;
        end
    end

    // Result fields track the count after the step.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_count <= n_count;
        end
    end

    assign w_cnt_ext      = {5'b0, r_res_count};
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_tag      = r_tag;
    assign o_out_priority = r_pri;
    assign o_fill_count   = w_cnt_ext[4:0];
    assign o_is_empty     = (r_res_count == '0);

`ifndef SYNTHESIS
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == int'(r_count))
        else $error("occupied cells disagree with count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ent[1].vld |-> (w_ent[0].vld && (w_ent[0].pri >= w_ent[1].pri)))
        else $error("front pair out of order");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("insert did not grow queue");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rem |=> (r_count == $past(r_count) - CntW'(1)))
        else $error("remove did not shrink queue");
`endif

endmodule

`default_nettype wire
